// ===== rtl/core/assert_macros.svh =====
// assertion macros used by eld_ctrl in the decoder rtl
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ELD_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ELD_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/eld_pkg.sv =====
// types, character codes and helper functions for the escaped literal decoder
// no dependencies
package eld_pkg;

	typedef enum logic [1:0] {PH_NORMAL, PH_ESCAPE, PH_HEX, PH_DONE} phase_t;
	typedef enum logic [1:0] {LET_X, LET_LU, LET_UU} letter_t;
	typedef enum logic [1:0] {KIND_BYTE, KIND_CLOSE, KIND_ERROR} kind_t;
	typedef enum logic [1:0] {EV_NONE, EV_ONE, EV_HEXFIN, EV_BADHEX} eval_act_t;
	typedef enum logic [2:0] {OS_EVAL, OS_FIN_ERR, OS_LETTER, OS_DIGIT, OS_UTF} out_sel_t;
	typedef enum logic [2:0] {S_IDLE, S_EVAL, S_FIN, S_UTF, S_LETTER, S_DIGITS} state_t;

	typedef struct packed {
		logic      accept;
		logic      eval_commit;
		logic      fin_commit;
		logic      set_normal;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      load_out;
		out_sel_t  out_sel;
		logic      out_last;
	} dp_cmd_t;

	typedef struct packed {
		eval_act_t eval_act;
		logic      fin_err;
		logic      plain_emits;
		logic      digits_zero;
		logic      digit_last;
		logic      utf_last;
	} dp_status_t;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_BAR = 8'h7c;
	localparam logic [7:0] CH_BSL = 8'h5c;
	localparam logic [7:0] CH_A   = 8'h61;
	localparam logic [7:0] CH_B   = 8'h62;
	localparam logic [7:0] CH_F   = 8'h66;
	localparam logic [7:0] CH_N   = 8'h6e;
	localparam logic [7:0] CH_R   = 8'h72;
	localparam logic [7:0] CH_T   = 8'h74;
	localparam logic [7:0] CH_V   = 8'h76;
	localparam logic [7:0] CH_X   = 8'h78;
	localparam logic [7:0] CH_LU  = 8'h75;
	localparam logic [7:0] CH_UU  = 8'h55;

	localparam logic [7:0] BY_BEL = 8'h07;
	localparam logic [7:0] BY_BS  = 8'h08;
	localparam logic [7:0] BY_FF  = 8'h0c;
	localparam logic [7:0] BY_LF  = 8'h0a;
	localparam logic [7:0] BY_CR  = 8'h0d;
	localparam logic [7:0] BY_HT  = 8'h09;
	localparam logic [7:0] BY_VT  = 8'h0b;

	localparam logic [31:0] CP_MAX  = 32'h0010_ffff;
	localparam logic [31:0] SURR_LO = 32'h0000_d800;
	localparam logic [31:0] SURR_HI = 32'h0000_dfff;
	localparam logic [31:0] LIM1    = 32'h0000_007f;
	localparam logic [31:0] LIM2    = 32'h0000_07ff;
	localparam logic [31:0] LIM3    = 32'h0000_ffff;
	localparam logic [7:0]  LEAD2   = 8'hc0;
	localparam logic [7:0]  LEAD3   = 8'he0;
	localparam logic [7:0]  LEAD4   = 8'hf0;
	localparam logic [7:0]  CONT    = 8'h80;

	function automatic logic is_hex(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] c);
		logic [3:0] v;
		if (c <= 8'h39) begin
			v = c[3:0];
		end else begin
			v = 4'(c[3:0] + 4'd9);
		end
		return v;
	endfunction

	function automatic logic [7:0] escape_map(logic [7:0] c);
		logic [7:0] b;
		case (c)
			CH_A: b = BY_BEL;
			CH_B: b = BY_BS;
			CH_F: b = BY_FF;
			CH_N: b = BY_LF;
			CH_R: b = BY_CR;
			CH_T: b = BY_HT;
			CH_V: b = BY_VT;
			default: b = c;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] letter_char(letter_t l);
		logic [7:0] c;
		case (l)
			LET_X: c = CH_X;
			LET_LU: c = CH_LU;
			default: c = CH_UU;
		endcase
		return c;
	endfunction

	// true when the digit now arriving completes the escape
	function automatic logic hex_done(letter_t l, logic [3:0] digits);
		logic d;
		case (l)
			LET_X: d = (digits >= 4'd1);
			LET_LU: d = (digits >= 4'd3);
			default: d = (digits >= 4'd7);
		endcase
		return d;
	endfunction

	function automatic logic [1:0] utf_len_m1(logic [31:0] v);
		logic [1:0] n;
		if (v <= LIM1) begin
			n = 2'd0;
		end else if (v <= LIM2) begin
			n = 2'd1;
		end else if (v <= LIM3) begin
			n = 2'd2;
		end else begin
			n = 2'd3;
		end
		return n;
	endfunction

	function automatic logic [7:0] utf_byte(logic [31:0] v, logic [1:0] len_m1,
			logic [1:0] idx);
		logic [1:0] j;
		logic [7:0] b;
		j = 2'(len_m1 - idx);
		if (idx == 2'd0) begin
			case (len_m1)
				2'd0: b = v[7:0];
				2'd1: b = LEAD2 | {3'b0, v[10:6]};
				2'd2: b = LEAD3 | {4'b0, v[15:12]};
				default: b = LEAD4 | {5'b0, v[20:18]};
			endcase
		end else begin
			case (j)
				2'd0: b = CONT | {2'b0, v[5:0]};
				2'd1: b = CONT | {2'b0, v[11:6]};
				default: b = CONT | {2'b0, v[17:12]};
			endcase
		end
		return b;
	endfunction

endpackage

// ===== rtl/core/eld_datapath.sv =====
// decoder datapath: parse state, digit buffer, offset counter, result register
// depends on eld_pkg, driven by eld_ctrl
module eld_datapath #(
	parameter int OFFSET_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_char,
	input  logic              first_char,
	input  eld_pkg::dp_cmd_t  cmd,
	output eld_pkg::dp_status_t st,
	output logic [1:0]        out_kind,
	output logic [7:0]        out_byte,
	output logic [15:0]       stop_offset,
	output logic              last_of_run
);
	import eld_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
	localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

	logic [7:0]             char_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] esc_q;
	phase_t                 phase_q;
	letter_t                letter_q;
	logic [3:0]             digits_q;
	logic [31:0]            code_q;
	logic [7:0]             buf_q [8];
	logic [2:0]             cnt_q;
	kind_t                  kind_q;
	logic [7:0]             byte_q;
	logic [15:0]            off_q;
	logic                   last_q;

	logic [OFFSET_BITS-1:0] pos_inc;
	logic [OFFSET_BITS-1:0] pos_sat;
	logic                   is_digit;
	logic [1:0]             len_m1;
	eval_act_t              eval_act;
	kind_t                  eval_kind;
	logic [7:0]             eval_byte;
	logic [OFFSET_BITS-1:0] eval_off;

	assign pos_inc  = (pos_q == OFF_MAX) ? OFF_MAX : pos_q + 1'b1;
	assign pos_sat  = pos_inc;
	assign is_digit = is_hex(char_q);
	assign len_m1   = (letter_q == LET_X) ? 2'd0 : utf_len_m1(code_q);

	always_comb begin
		eval_act  = EV_NONE;
		eval_kind = KIND_BYTE;
		eval_byte = char_q;
		eval_off  = '0;
		case (phase_q)
			PH_NORMAL: begin
				if (char_q == CH_NUL || char_q == CH_LF) begin
					eval_act  = EV_ONE;
					eval_kind = KIND_ERROR;
					eval_byte = 8'h00;
					eval_off  = pos_q;
				end else if (char_q == CH_BAR) begin
					eval_act  = EV_ONE;
					eval_kind = KIND_CLOSE;
					eval_byte = 8'h00;
					eval_off  = pos_sat;
				end else if (char_q != CH_BSL) begin
					eval_act = EV_ONE;
				end
			end
			PH_ESCAPE: begin
				if (char_q == CH_NUL || char_q == CH_LF) begin
					eval_act  = EV_ONE;
					eval_kind = KIND_ERROR;
					eval_byte = 8'h00;
					eval_off  = esc_q;
				end else if (char_q != CH_X && char_q != CH_LU && char_q != CH_UU) begin
					eval_act  = EV_ONE;
					eval_byte = escape_map(char_q);
				end
			end
			PH_HEX: begin
				if (!is_digit) begin
					eval_act = EV_BADHEX;
				end else if (hex_done(letter_q, digits_q)) begin
					eval_act = EV_HEXFIN;
				end
			end
			default: begin
				eval_act = EV_NONE;
			end
		endcase
	end

	always_comb begin
		st.eval_act    = eval_act;
		if (letter_q == LET_X) begin
			st.fin_err = (code_q == 32'd0);
		end else begin
			st.fin_err = (code_q == 32'd0) || (code_q > CP_MAX) ||
				(code_q >= SURR_LO && code_q <= SURR_HI);
		end
		st.plain_emits = (char_q != CH_BSL);
		st.digits_zero = (digits_q == 4'd0);
		st.digit_last  = ({1'b0, cnt_q} == 4'(digits_q - 4'd1));
		st.utf_last    = (cnt_q[1:0] == len_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			esc_q    <= '0;
			phase_q  <= PH_NORMAL;
			letter_q <= LET_X;
			digits_q <= '0;
			code_q   <= '0;
		end else if (cmd.accept) begin
			if (first_char) begin
				pos_q    <= OFF_ONE;
				esc_q    <= '0;
				phase_q  <= PH_NORMAL;
				letter_q <= LET_X;
				digits_q <= '0;
				code_q   <= '0;
			end else begin
				pos_q <= pos_inc;
			end
		end else if (cmd.eval_commit) begin
			case (phase_q)
				PH_NORMAL: begin
					if (char_q == CH_NUL || char_q == CH_LF || char_q == CH_BAR) begin
						phase_q <= PH_DONE;
					end else if (char_q == CH_BSL) begin
						esc_q   <= pos_q;
						phase_q <= PH_ESCAPE;
					end
				end
				PH_ESCAPE: begin
					if (char_q == CH_NUL || char_q == CH_LF) begin
						phase_q <= PH_DONE;
					end else if (char_q == CH_X || char_q == CH_LU || char_q == CH_UU) begin
						letter_q <= (char_q == CH_X) ? LET_X :
							(char_q == CH_LU) ? LET_LU : LET_UU;
						digits_q <= '0;
						code_q   <= '0;
						phase_q  <= PH_HEX;
					end else begin
						phase_q <= PH_NORMAL;
					end
				end
				PH_HEX: begin
					if (is_digit) begin
						code_q   <= {code_q[27:0], hex_val(char_q)};
						digits_q <= 4'(digits_q + 4'd1);
					end
				end
				default: begin
					phase_q <= phase_q;
				end
			endcase
		end else if (cmd.fin_commit) begin
			phase_q <= st.fin_err ? PH_DONE : PH_NORMAL;
		end else if (cmd.set_normal) begin
			phase_q <= PH_NORMAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= 3'(cnt_q + 3'd1);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			char_q <= in_char;
		end
		if (cmd.eval_commit && phase_q == PH_HEX && is_digit) begin
			buf_q[digits_q[2:0]] <= char_q;
		end
		if (cmd.load_out) begin
			last_q <= cmd.out_last;
			case (cmd.out_sel)
				OS_EVAL: begin
					kind_q <= eval_kind;
					byte_q <= eval_byte;
					off_q  <= 16'(eval_off);
				end
				OS_FIN_ERR: begin
					kind_q <= KIND_ERROR;
					byte_q <= 8'h00;
					off_q  <= 16'(esc_q);
				end
				OS_LETTER: begin
					kind_q <= KIND_BYTE;
					byte_q <= letter_char(letter_q);
					off_q  <= '0;
				end
				OS_DIGIT: begin
					kind_q <= KIND_BYTE;
					byte_q <= buf_q[cnt_q];
					off_q  <= '0;
				end
				default: begin
					kind_q <= KIND_BYTE;
					byte_q <= utf_byte(code_q, len_m1, cnt_q[1:0]);
					off_q  <= '0;
				end
			endcase
		end
	end

	assign out_kind    = 2'(kind_q);
	assign out_byte    = byte_q;
	assign stop_offset = off_q;
	assign last_of_run = last_q;

endmodule

// ===== rtl/core/eld_ctrl.sv =====
// decoder controller: sequencing state machine and result valid flag
// depends on eld_pkg and assert_macros.svh, drives eld_datapath
`include "assert_macros.svh"

module eld_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  eld_pkg::dp_status_t st,
	output eld_pkg::dp_cmd_t    cmd
);
	import eld_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.out_sel = OS_EVAL;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EVAL;
				end
			end
			S_EVAL: begin
				case (st.eval_act)
					EV_NONE: begin
						cmd.eval_commit = 1'b1;
						state_d         = S_IDLE;
					end
					EV_ONE: begin
						if (slot_free) begin
							cmd.eval_commit = 1'b1;
							cmd.load_out    = 1'b1;
							cmd.out_sel     = OS_EVAL;
							cmd.out_last    = 1'b1;
							state_d         = S_IDLE;
						end
					end
					EV_HEXFIN: begin
						cmd.eval_commit = 1'b1;
						state_d         = S_FIN;
					end
					default: begin
						state_d = S_LETTER;
					end
				endcase
			end
			S_FIN: begin
				if (st.fin_err) begin
					if (slot_free) begin
						cmd.fin_commit = 1'b1;
						cmd.load_out   = 1'b1;
						cmd.out_sel    = OS_FIN_ERR;
						cmd.out_last   = 1'b1;
						state_d        = S_IDLE;
					end
				end else begin
					cmd.fin_commit = 1'b1;
					cmd.cnt_clr    = 1'b1;
					state_d        = S_UTF;
				end
			end
			S_UTF: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = OS_UTF;
					cmd.out_last = st.utf_last;
					cmd.cnt_inc  = 1'b1;
					if (st.utf_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_LETTER: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = OS_LETTER;
					cmd.out_last = st.digits_zero && !st.plain_emits;
					if (st.digits_zero) begin
						cmd.set_normal = 1'b1;
						state_d        = S_EVAL;
					end else begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_DIGITS;
					end
				end
			end
			S_DIGITS: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = OS_DIGIT;
					cmd.out_last = st.digit_last && !st.plain_emits;
					if (st.digit_last) begin
						cmd.set_normal = 1'b1;
						state_d        = S_EVAL;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`ELD_NEXT(a_eval_after_accept, in_valid && in_ready, state_q == S_EVAL, "accepted beat not evaluated")
	`ELD_IMPL(a_load_slot_free, cmd.load_out, !out_valid_q || out_ready, "result register overwritten")
	`ELD_IMPL(a_digits_nonempty, state_q == S_DIGITS, !st.digits_zero, "digit replay with empty buffer")
	`ELD_IMPL(a_utf_code_valid, state_q == S_UTF, !st.fin_err, "utf-8 output from invalid code point")

endmodule

// ===== rtl/core/escaped_literal_decoder.sv =====
// escaped literal decoder top level: eld_ctrl plus eld_datapath, types from eld_pkg
// plain beat: accepted in idle and evaluated in the next cycle, its result registered in eval
// completed hex escape: eval, fin checks the code point, utf registers each utf-8 byte; bad hex
// digit: letter and digits replay the buffered text, then eval takes the bad byte as plain text;
// fin registers a hex error; a result beat still waiting in the output register stalls each load
// asynchronous active-low reset: idle, normal text, offset and result valid cleared
module escaped_literal_decoder #(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_char,
	input  logic        first_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic [15:0] stop_offset,
	output logic        last_of_run
);
	import eld_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	eld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	eld_datapath #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_char     (in_char),
		.first_char  (first_char),
		.cmd         (cmd),
		.st          (st),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.stop_offset (stop_offset),
		.last_of_run (last_of_run)
	);

endmodule

// ===== bench/testbench.sv =====
// testbench for escaped_literal_decoder: directed and random literal text checked beat by beat
// against an in-bench decoder model, with random input idling and random output back-pressure
// depends on eld_pkg and the decoder rtl
module testbench;
	import eld_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		logic [15:0] offset;
		logic        last;
	} decoded_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_char = 8'h00;
	logic        first_char = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic [15:0] stop_offset;
	logic        last_of_run;

	// decoder model state
	phase_t      lit_phase = PH_NORMAL;
	letter_t     esc_letter = LET_X;
	logic [3:0]  digit_count = 4'd0;
	logic [31:0] code_acc = 32'd0;
	logic [7:0]  digit_hold [8];
	logic [15:0] byte_pos = 16'd0;
	logic [15:0] esc_pos = 16'd0;

	decoded_t    run_results[$];
	decoded_t    decoded_q[$];
	logic [7:0]  lit_text[$];

	logic        calm = 1'b0;
	int          stall_request = 0;
	int          mismatches = 0;
	int          beats_in = 0;
	int          live_items = 0;
	int          beats_out = 0;
	int          closed_lits = 0;
	int          error_lits = 0;

	escaped_literal_decoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_char(in_char),
		.first_char(first_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.stop_offset(stop_offset),
		.last_of_run(last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] next_offset(logic [15:0] off);
		return (off == 16'hffff) ? off : off + 16'd1;
	endfunction

	function automatic int hex_digit_of(logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c) - int'("0");
		end else if (c >= "a" && c <= "f") begin
			return int'(c) - int'("a") + 10;
		end else if (c >= "A" && c <= "F") begin
			return int'(c) - int'("A") + 10;
		end
		return -1;
	endfunction

	function automatic logic [31:0] pick_code_point();
		case ($urandom_range(7))
			0: return 32'($urandom_range(1, 'h7f));
			1: return 32'($urandom_range('h80, 'h7ff));
			2: return 32'($urandom_range('h800, 'hffff));
			3: return 32'($urandom_range('h10000, 'h10ffff));
			4: return 32'($urandom_range('hd800, 'hdfff));
			5: return 32'h0;
			6: return $urandom_range(1) ? 32'h0011_0000 : ($urandom | 32'h0011_0000);
			default: begin
				case ($urandom_range(9))
					0: return 32'h7f;
					1: return 32'h80;
					2: return 32'h7ff;
					3: return 32'h800;
					4: return 32'hd7ff;
					5: return SURR_HI + 32'd1;
					6: return 32'hffff;
					7: return 32'h10000;
					8: return 32'h1;
					default: return CP_MAX;
				endcase
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic expect_beat(input kind_t kind, input logic [7:0] value,
			input logic [15:0] offset);
		decoded_t d;
		if (run_results.size() < 10) begin
			d.kind = kind;
			d.value = value;
			d.offset = offset;
			d.last = 1'b0;
			run_results = {run_results, d};
		end
	endtask

	task automatic stop_literal(input logic [15:0] off);
		expect_beat(KIND_ERROR, 8'h00, off);
		lit_phase = PH_DONE;
	endtask

	task automatic take_plain(input logic [7:0] c, input logic [15:0] off);
		if (c == CH_NUL || c == CH_LF) begin
			stop_literal(off);
		end else if (c == CH_BAR) begin
			expect_beat(KIND_CLOSE, 8'h00, next_offset(off));
			lit_phase = PH_DONE;
		end else if (c == CH_BSL) begin
			esc_pos = off;
			lit_phase = PH_ESCAPE;
		end else begin
			expect_beat(KIND_BYTE, c, 16'h0);
		end
	endtask

	// works out the result beats of one accepted input beat
	task automatic decode_byte(input logic [7:0] c, input logic opening);
		logic [15:0] off;
		logic [31:0] cp;
		int          need;
		int          hexv;
		decoded_t    d;
		run_results.delete();
		if (opening) begin
			lit_phase = PH_NORMAL;
			esc_letter = LET_X;
			digit_count = 4'd0;
			code_acc = 32'd0;
			esc_pos = 16'd0;
			off = 16'd1;
		end else begin
			off = next_offset(byte_pos);
		end
		byte_pos = off;
		if (lit_phase != PH_DONE) begin
			live_items++;
		end
		case (lit_phase)
			PH_NORMAL: take_plain(c, off);
			PH_ESCAPE: begin
				lit_phase = PH_NORMAL;
				case (c)
					CH_NUL, CH_LF: stop_literal(esc_pos);
					CH_A: expect_beat(KIND_BYTE, BY_BEL, 16'h0);
					CH_B: expect_beat(KIND_BYTE, BY_BS, 16'h0);
					CH_F: expect_beat(KIND_BYTE, BY_FF, 16'h0);
					CH_N: expect_beat(KIND_BYTE, BY_LF, 16'h0);
					CH_R: expect_beat(KIND_BYTE, BY_CR, 16'h0);
					CH_T: expect_beat(KIND_BYTE, BY_HT, 16'h0);
					CH_V: expect_beat(KIND_BYTE, BY_VT, 16'h0);
					CH_X, CH_LU, CH_UU: begin
						esc_letter = (c == CH_X) ? LET_X : (c == CH_LU) ? LET_LU : LET_UU;
						digit_count = 4'd0;
						code_acc = 32'd0;
						lit_phase = PH_HEX;
					end
					default: expect_beat(KIND_BYTE, c, 16'h0);
				endcase
			end
			PH_HEX: begin
				need = (esc_letter == LET_X) ? 2 : (esc_letter == LET_LU) ? 4 : 8;
				hexv = hex_digit_of(c);
				if (hexv >= 0) begin
					digit_hold[digit_count[2:0]] = c;
					code_acc = {code_acc[27:0], 4'(hexv)};
					digit_count = digit_count + 4'd1;
					if (digit_count >= need) begin
						lit_phase = PH_NORMAL;
						cp = code_acc;
						if (esc_letter == LET_X) begin
							if (cp == 32'd0) begin
								stop_literal(esc_pos);
							end else begin
								expect_beat(KIND_BYTE, cp[7:0], 16'h0);
							end
						end else if (cp == 32'd0 || cp > CP_MAX ||
								(cp >= SURR_LO && cp <= SURR_HI)) begin
							stop_literal(esc_pos);
						end else if (cp <= LIM1) begin
							expect_beat(KIND_BYTE, cp[7:0], 16'h0);
						end else if (cp <= LIM2) begin
							expect_beat(KIND_BYTE, LEAD2 | {3'b0, cp[10:6]}, 16'h0);
							expect_beat(KIND_BYTE, CONT | {2'b0, cp[5:0]}, 16'h0);
						end else if (cp <= LIM3) begin
							expect_beat(KIND_BYTE, LEAD3 | {4'b0, cp[15:12]}, 16'h0);
							expect_beat(KIND_BYTE, CONT | {2'b0, cp[11:6]}, 16'h0);
							expect_beat(KIND_BYTE, CONT | {2'b0, cp[5:0]}, 16'h0);
						end else begin
							expect_beat(KIND_BYTE, LEAD4 | {5'b0, cp[20:18]}, 16'h0);
							expect_beat(KIND_BYTE, CONT | {2'b0, cp[17:12]}, 16'h0);
							expect_beat(KIND_BYTE, CONT | {2'b0, cp[11:6]}, 16'h0);
							expect_beat(KIND_BYTE, CONT | {2'b0, cp[5:0]}, 16'h0);
						end
					end
				end else begin
					// bad digit: replay letter and buffered digits, then treat as text
					expect_beat(KIND_BYTE, (esc_letter == LET_X) ? CH_X :
						(esc_letter == LET_LU) ? CH_LU : CH_UU, 16'h0);
					for (int i = 0; i < digit_count && i < 8; i++) begin
						expect_beat(KIND_BYTE, digit_hold[i], 16'h0);
					end
					lit_phase = PH_NORMAL;
					take_plain(c, off);
				end
			end
			default: ;
		endcase
		if (run_results.size() > 0) begin
			run_results[run_results.size() - 1].last = 1'b1;
		end
		foreach (run_results[i]) begin
			d = run_results[i];
			decoded_q = {decoded_q, d};
		end
	endtask

	// sends one input beat, called and returning at a falling edge
	task automatic offer_byte(input logic [7:0] c, input logic opening);
		int gap;
		if (!calm && $urandom_range(99) < 29) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_char = c;
		first_char = opening;
		do begin
			@(posedge clk);
		end while (!in_ready);
		decode_byte(c, opening);
		beats_in++;
		@(negedge clk);
	endtask

	task automatic offer_string(input string s, input logic opening);
		for (int i = 0; i < s.len(); i++) begin
			offer_byte(s[i], opening && (i == 0));
		end
	endtask

	task automatic add_text(input logic [7:0] c);
		lit_text = {lit_text, c};
	endtask

	task automatic append_hex(input logic [31:0] value, input int n);
		logic [3:0] nib;
		for (int i = n - 1; i >= 0; i--) begin
			nib = value[i*4 +: 4];
			if (nib < 4'd10) begin
				add_text(8'("0" + nib));
			end else if ($urandom_range(1)) begin
				add_text(8'("a" + nib - 4'd10));
			end else begin
				add_text(8'("A" + nib - 4'd10));
			end
		end
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (decoded_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic test_before_first();
		offer_byte("Z", 1'b0);
		offer_byte(8'hff, 1'b0);
	endtask

	task automatic test_utf8_extremes();
		offer_string("\\U0010FFFf|", 1'b1);
	endtask

	task automatic test_bad_hex();
		offer_string("\\xg\\q", 1'b1);
	endtask

	task automatic test_stop_cases();
		offer_byte(CH_LF, 1'b0);
		offer_byte("7", 1'b0);
		offer_string("\\x00", 1'b1);
		offer_byte(CH_NUL, 1'b1);
		offer_string("k\\", 1'b1);
		offer_byte(CH_LF, 1'b0);
	endtask

	task automatic test_backpressure();
		stall_request = 80;
		offer_string("\\U0001F600\\u20AC\\U0010fffF\\x7E\\u00e9abc|", 1'b1);
		wait_drained();
	endtask

	task automatic test_random_literals();
		int         base;
		int         k;
		logic [7:0] c;
		base = beats_in;
		while (beats_in - base < 130) begin
			calm = (beats_in - base >= 40 && beats_in - base < 80);
			if ($urandom_range(99) < 15) begin
				repeat ($urandom_range(1, 6)) begin
					offer_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
				end
			end else begin
				lit_text.delete();
				repeat ($urandom_range(1, 10)) begin
					case ($urandom_range(9))
						0, 1, 2, 3: begin
							do begin
								c = 8'($urandom_range(1, 255));
							end while (c == CH_LF || c == CH_BAR || c == CH_BSL);
							add_text(c);
						end
						4: begin
							case ($urandom_range(8))
								0: c = CH_BSL;
								1: c = CH_BAR;
								2: c = CH_A;
								3: c = CH_B;
								4: c = CH_F;
								5: c = CH_N;
								6: c = CH_R;
								7: c = CH_T;
								default: c = CH_V;
							endcase
							add_text(CH_BSL);
							add_text(c);
						end
						5: begin
							do begin
								c = 8'($urandom_range(255));
							end while (c == CH_X || c == CH_LU || c == CH_UU);
							add_text(CH_BSL);
							add_text(c);
						end
						6: begin
							add_text(CH_BSL);
							add_text(CH_X);
							append_hex(($urandom_range(9) == 0) ? 32'h0 :
								32'($urandom_range(1, 255)), 2);
						end
						7: begin
							add_text(CH_BSL);
							add_text(CH_LU);
							append_hex(pick_code_point(), 4);
						end
						8: begin
							add_text(CH_BSL);
							add_text(CH_UU);
							append_hex(pick_code_point(), 8);
						end
						default: begin
							// escape cut short by a non-hex byte
							case ($urandom_range(2))
								0: begin
									c = CH_X;
									k = $urandom_range(1);
								end
								1: begin
									c = CH_LU;
									k = $urandom_range(3);
								end
								default: begin
									c = CH_UU;
									k = $urandom_range(1) ? 7 : $urandom_range(6);
								end
							endcase
							add_text(CH_BSL);
							add_text(c);
							append_hex($urandom, k);
							do begin
								c = 8'($urandom_range(255));
							end while (hex_digit_of(c) >= 0);
							add_text(c);
						end
					endcase
				end
				case ($urandom_range(9))
					0: add_text(CH_LF);
					1: add_text(CH_NUL);
					2: ;
					default: add_text(CH_BAR);
				endcase
				foreach (lit_text[i]) begin
					offer_byte(lit_text[i], i == 0);
				end
			end
		end
		calm = 1'b0;
	endtask

	initial begin : ready_drive
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (stall_request > 0) begin
				hold_left = stall_request;
				stall_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else begin
				out_ready = calm || ($urandom_range(99) >= 29);
			end
		end
	end

	initial begin : result_check
		decoded_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				beats_out++;
				if (out_kind == KIND_CLOSE) begin
					closed_lits++;
				end else if (out_kind == KIND_ERROR) begin
					error_lits++;
				end
				if (decoded_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat kind %0d byte %02h offset %0d",
						out_kind, out_byte, stop_offset));
				end else begin
					want = decoded_q.pop_front();
					if (out_kind !== want.kind || out_byte !== want.value ||
							stop_offset !== want.offset || last_of_run !== want.last) begin
						report_mismatch($sformatf(
							"got kind %0d byte %02h offset %0d last %0b, want %0d %02h %0d %0b",
							out_kind, out_byte, stop_offset, last_of_run,
							want.kind, want.value, want.offset, want.last));
					end
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("no beat moved for %0d cycles, %0d results outstanding", STALL_LIMIT,
			decoded_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_before_first();
		test_utf8_extremes();
		test_bad_hex();
		test_stop_cases();
		test_backpressure();
		test_random_literals();
		wait_drained();
		repeat (20) @(negedge clk);
		$display("sent %0d input beats (%0d decoded), checked %0d result beats", beats_in,
			live_items, beats_out);
		$display("%0d literals closed, %0d stopped on an error, one long output stall drained",
			closed_lits, error_lits);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
